// ===== design/wilder_rsi_stream_core_assert.svh =====
// assertion helpers for the wilder rsi stream core
`ifndef WILDER_RSI_STREAM_CORE_ASSERT_SVH
`define WILDER_RSI_STREAM_CORE_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define WRSI_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wilder rsi stream core check failed");

// condition that must never be seen outside reset
`define WRSI_ASSERT_NEVER(name, cond) \
  `WRSI_ASSERT(name, (!(cond)))

`endif

// ===== design/wrsi_pkg.sv =====
package wrsi_pkg;

  // configuration register
  localparam int unsigned CFG_W = 11;
  localparam logic [CFG_W-1:0] PERIOD_RESET = 11'd14;

  // running averages and change scaling
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned EXTRA_FRAC = 16;

  // index output
  localparam int unsigned RSI_W = 23;
  localparam logic [RSI_W-1:0] RSI_FULL = 23'd6553600;

  // normalization bound on gain plus loss (divisor width)
  localparam int unsigned NORM_W = 40;

  // chunked multiplier
  localparam int unsigned MUL_M_W   = 17;
  localparam logic [MUL_M_W-1:0] RSI_SCALE = 17'd100;
  localparam int unsigned MUL_CHUNK = 16;
  localparam int unsigned MUL_STEPS = ACC_W / MUL_CHUNK;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);

  // radix-2 divider, one quotient bit per cycle
  localparam int unsigned DIV_CNT_W = $clog2(ACC_W);

  // operand source of the shared multiplier and divider
  typedef enum logic [1:0] {
    SRC_GAIN = 2'd0,
    SRC_LOSS = 2'd1,
    SRC_RSI  = 2'd2
  } src_e;

  // kind of result written to the output register
  typedef enum logic [1:0] {
    RES_NULL = 2'd0,
    RES_FULL = 2'd1,
    RES_QUO  = 2'd2
  } res_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic seed;
    logic take_change;
    logic accum;
    logic add_gain;
    logic add_loss;
    logic norm_load;
    logic norm_shift;
    logic mul_run;
    logic div_run;
    src_e src;
    logic emit;
    res_e res_kind;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic absent;
    logic started;
    logic warm;
    logic fill_last;
    logic mul_last;
    logic div_last;
    logic loss_zero;
    logic norm_big;
    logic norm_zero;
    logic out_free;
  } status_t;

endpackage

// ===== design/wrsi_mul.sv =====
module wrsi_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               run_i,
  input  logic [wrsi_pkg::ACC_W-1:0]         a_i,
  input  logic [wrsi_pkg::MUL_M_W-1:0]       m_i,
  output logic [wrsi_pkg::ACC_W-1:0]         prod_o,
  output logic                               last_o
);

  localparam int unsigned PP_W = wrsi_pkg::MUL_CHUNK + wrsi_pkg::MUL_M_W;

  logic [wrsi_pkg::MUL_CNT_W-1:0] cnt_q;
  logic [wrsi_pkg::ACC_W-1:0]     acc_q, acc_d, term;
  logic [wrsi_pkg::MUL_CHUNK-1:0] chunk;
  logic [PP_W-1:0]                pp;

  // one 16-bit chunk of the multiplicand per cycle, product kept modulo 2^64
  always_comb begin
    chunk  = a_i[cnt_q*wrsi_pkg::MUL_CHUNK +: wrsi_pkg::MUL_CHUNK];
    pp     = PP_W'(chunk) * PP_W'(m_i);
    term   = wrsi_pkg::ACC_W'(pp) << (cnt_q * wrsi_pkg::MUL_CHUNK);
    acc_d  = (cnt_q == '0) ? term : acc_q + term;
    last_o = run_i && (cnt_q == wrsi_pkg::MUL_CNT_W'(wrsi_pkg::MUL_STEPS - 1));
  end

  assign prod_o = acc_q;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (run_i) begin
      cnt_q <= cnt_q + 1'b1;
    end else begin
      cnt_q <= '0;
    end
  end

  // accumulator
  always_ff @(posedge clk_i) begin
    if (run_i) begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== design/wrsi_div.sv =====
module wrsi_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          run_i,
  input  logic [wrsi_pkg::ACC_W-1:0]    dividend_i,
  input  logic [wrsi_pkg::NORM_W-1:0]   divisor_i,
  output logic [wrsi_pkg::ACC_W-1:0]    quot_next_o,
  output logic [wrsi_pkg::ACC_W-1:0]    quot_o,
  output logic                          last_o
);

  logic [wrsi_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [wrsi_pkg::NORM_W-1:0]    rem_q, rem_d, rem_base;
  logic [wrsi_pkg::NORM_W:0]      trial, diff;
  logic [wrsi_pkg::ACC_W-1:0]     quo_q, quo_d;
  logic                           ge;

  // restoring division, dividend bits taken msb first
  always_comb begin
    rem_base    = (cnt_q == '0) ? '0 : rem_q;
    trial       = {rem_base, dividend_i[~cnt_q]};
    diff        = trial - {1'b0, divisor_i};
    ge          = (trial >= {1'b0, divisor_i});
    rem_d       = ge ? diff[wrsi_pkg::NORM_W-1:0] : trial[wrsi_pkg::NORM_W-1:0];
    quo_d       = {quo_q[wrsi_pkg::ACC_W-2:0], ge};
    last_o      = run_i && (&cnt_q);
    quot_next_o = quo_d;
  end

  assign quot_o = quo_q;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (run_i) begin
      cnt_q <= cnt_q + 1'b1;
    end else begin
      cnt_q <= '0;
    end
  end

  // partial remainder and quotient
  always_ff @(posedge clk_i) begin
    if (run_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

endmodule

// ===== design/wrsi_dpath.sv =====
module wrsi_dpath #(
  parameter int unsigned MAX_PERIOD  = 1024,
  parameter int unsigned PRICE_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wrsi_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic signed [PRICE_WIDTH-1:0]    price_i,
  input  logic                             price_absent_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [wrsi_pkg::RSI_W-1:0]       rsi_o,
  output logic                             rsi_valid_o,
  output logic                             fault_o,
  input  wrsi_pkg::cmd_t                   cmd_i,
  output wrsi_pkg::status_t                stat_o
);

  localparam int unsigned PERIOD_W = $clog2(MAX_PERIOD + 1);
  localparam int unsigned CMP_W    = (PERIOD_W > wrsi_pkg::CFG_W) ? PERIOD_W : wrsi_pkg::CFG_W;
  localparam logic [PRICE_WIDTH-1:0] SIGN_BIT = {1'b1, {(PRICE_WIDTH-1){1'b0}}};

  // configuration and item capture
  logic [wrsi_pkg::CFG_W-1:0] period_q;
  logic [PRICE_WIDTH-1:0]     price_q;
  logic                       absent_q;

  // series state
  logic                        started_q;
  logic [PERIOD_W-1:0]         change_count_q;
  logic [PRICE_WIDTH-1:0]      last_price_q;
  logic [wrsi_pkg::ACC_W-1:0]  gain_q, loss_q;

  // work registers: the change, then the normalized gain and loss
  logic [wrsi_pkg::ACC_W-1:0]  tmp_g_q, tmp_l_q;

  // output register
  logic                        out_valid_q;
  logic [wrsi_pkg::RSI_W-1:0]  rsi_q;
  logic                        rsi_valid_q, fault_q;

  logic [CMP_W-1:0]            period_ext;
  logic [PERIOD_W-1:0]         p;
  logic [PERIOD_W:0]           count_next;
  logic [PRICE_WIDTH-1:0]      now_b, old_b, mag;
  logic                        up;
  logic [wrsi_pkg::ACC_W-1:0]  change;
  logic [wrsi_pkg::ACC_W-1:0]  norm_sum;

  logic [wrsi_pkg::ACC_W-1:0]   mul_a, mul_prod;
  logic [wrsi_pkg::MUL_M_W-1:0] mul_m;
  logic                         mul_last;
  logic [wrsi_pkg::ACC_W-1:0]   div_n, div_qn, div_q;
  logic [wrsi_pkg::NORM_W-1:0]  div_d;
  logic                         div_last, div_wb_gain, div_wb_loss;

  // effective window, zero acts as one and large values saturate
  always_comb begin
    period_ext = CMP_W'(period_q);
    if (period_ext == '0) begin
      p = PERIOD_W'(1);
    end else if (period_ext > CMP_W'(MAX_PERIOD)) begin
      p = PERIOD_W'(MAX_PERIOD);
    end else begin
      p = PERIOD_W'(period_ext);
    end
    count_next = (PERIOD_W+1)'(change_count_q) + 1'b1;
  end

  // price change in offset form, split into gain or loss magnitude
  always_comb begin
    now_b  = price_q ^ SIGN_BIT;
    old_b  = last_price_q ^ SIGN_BIT;
    up     = (now_b > old_b);
    mag    = up ? (now_b - old_b) : (old_b - now_b);
    change = wrsi_pkg::ACC_W'(mag) << wrsi_pkg::EXTRA_FRAC;
  end

  assign norm_sum = tmp_g_q + tmp_l_q;

  // operand selection for the shared units
  always_comb begin
    case (cmd_i.src)
      wrsi_pkg::SRC_GAIN: begin
        mul_a = gain_q;
        mul_m = wrsi_pkg::MUL_M_W'(p - 1'b1);
        div_n = gain_q;
        div_d = wrsi_pkg::NORM_W'(p);
      end
      wrsi_pkg::SRC_LOSS: begin
        mul_a = loss_q;
        mul_m = wrsi_pkg::MUL_M_W'(p - 1'b1);
        div_n = loss_q;
        div_d = wrsi_pkg::NORM_W'(p);
      end
      wrsi_pkg::SRC_RSI: begin
        mul_a = tmp_g_q;
        mul_m = wrsi_pkg::RSI_SCALE;
        div_n = mul_prod << wrsi_pkg::EXTRA_FRAC;
        div_d = norm_sum[wrsi_pkg::NORM_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_m = '0;
        div_n = '0;
        div_d = '0;
      end
    endcase
    div_wb_gain = cmd_i.div_run && div_last && (cmd_i.src == wrsi_pkg::SRC_GAIN);
    div_wb_loss = cmd_i.div_run && div_last && (cmd_i.src == wrsi_pkg::SRC_LOSS);
  end

  wrsi_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .run_i  (cmd_i.mul_run),
    .a_i    (mul_a),
    .m_i    (mul_m),
    .prod_o (mul_prod),
    .last_o (mul_last)
  );

  wrsi_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_i       (cmd_i.div_run),
    .dividend_i  (div_n),
    .divisor_i   (div_d),
    .quot_next_o (div_qn),
    .quot_o      (div_q),
    .last_o      (div_last)
  );

  // status to the controller
  always_comb begin
    stat_o.absent    = absent_q;
    stat_o.started   = started_q;
    stat_o.warm      = (change_count_q < p);
    stat_o.fill_last = (count_next >= (PERIOD_W+1)'(p));
    stat_o.mul_last  = mul_last;
    stat_o.div_last  = div_last;
    stat_o.loss_zero = (loss_q == '0);
    stat_o.norm_big  = |norm_sum[wrsi_pkg::ACC_W-1:wrsi_pkg::NORM_W];
    stat_o.norm_zero = (norm_sum == '0);
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  // period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= wrsi_pkg::PERIOD_RESET;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  // series state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q      <= 1'b0;
      change_count_q <= '0;
      last_price_q   <= '0;
      gain_q         <= '0;
      loss_q         <= '0;
    end else begin
      if (cmd_i.seed) begin
        started_q    <= 1'b1;
        last_price_q <= price_q;
      end else if (cmd_i.take_change) begin
        last_price_q <= price_q;
      end
      if (cmd_i.accum) begin
        change_count_q <= change_count_q + 1'b1;
      end
      if (cmd_i.accum) begin
        gain_q <= gain_q + tmp_g_q;
      end else if (cmd_i.add_gain) begin
        gain_q <= mul_prod + tmp_g_q;
      end else if (div_wb_gain) begin
        gain_q <= div_qn;
      end
      if (cmd_i.accum) begin
        loss_q <= loss_q + tmp_l_q;
      end else if (cmd_i.add_loss) begin
        loss_q <= mul_prod + tmp_l_q;
      end else if (div_wb_loss) begin
        loss_q <= div_qn;
      end
    end
  end

  // captured item and work registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      price_q  <= price_i;
      absent_q <= price_absent_i;
    end
    if (cmd_i.take_change) begin
      tmp_g_q <= up ? change : '0;
      tmp_l_q <= up ? '0 : change;
    end else if (cmd_i.norm_load) begin
      tmp_g_q <= gain_q;
      tmp_l_q <= loss_q;
    end else if (cmd_i.norm_shift) begin
      tmp_g_q <= tmp_g_q >> 1;
      tmp_l_q <= tmp_l_q >> 1;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      case (cmd_i.res_kind)
        wrsi_pkg::RES_FULL: begin
          rsi_q       <= wrsi_pkg::RSI_FULL;
          rsi_valid_q <= 1'b1;
          fault_q     <= 1'b0;
        end
        wrsi_pkg::RES_QUO: begin
          rsi_q       <= div_q[wrsi_pkg::RSI_W-1:0];
          rsi_valid_q <= 1'b1;
          fault_q     <= 1'b0;
        end
        default: begin
          rsi_q       <= '0;
          rsi_valid_q <= 1'b0;
          fault_q     <= absent_q && started_q;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsi_o       = rsi_q;
  assign rsi_valid_o = rsi_valid_q;
  assign fault_o     = fault_q;

endmodule

// ===== design/wrsi_ctrl.sv =====
module wrsi_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wrsi_pkg::status_t    stat_i,
  output wrsi_pkg::cmd_t       cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_EVAL      = 14'b00000000000010,
    S_ACCUM     = 14'b00000000000100,
    S_MUL_G     = 14'b00000000001000,
    S_ADD_G     = 14'b00000000010000,
    S_MUL_L     = 14'b00000000100000,
    S_ADD_L     = 14'b00000001000000,
    S_DIV_G     = 14'b00000010000000,
    S_DIV_L     = 14'b00000100000000,
    S_NORM_LOAD = 14'b00001000000000,
    S_NORM      = 14'b00010000000000,
    S_MUL_R     = 14'b00100000000000,
    S_DIV_R     = 14'b01000000000000,
    S_OUT       = 14'b10000000000000
  } state_e;

  state_e         state_q, state_d;
  wrsi_pkg::res_e res_q, res_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and command decode
  always_comb begin
    state_d        = state_q;
    res_d          = res_q;
    cmd_o          = '0;
    cmd_o.src      = wrsi_pkg::SRC_GAIN;
    cmd_o.res_kind = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.absent) begin
          res_d   = wrsi_pkg::RES_NULL;
          state_d = S_OUT;
        end else if (!stat_i.started) begin
          cmd_o.seed = 1'b1;
          res_d      = wrsi_pkg::RES_NULL;
          state_d    = S_OUT;
        end else begin
          cmd_o.take_change = 1'b1;
          state_d           = stat_i.warm ? S_ACCUM : S_MUL_G;
        end
      end
      S_ACCUM: begin
        cmd_o.accum = 1'b1;
        if (stat_i.fill_last) begin
          state_d = S_DIV_G;
        end else begin
          res_d   = wrsi_pkg::RES_NULL;
          state_d = S_OUT;
        end
      end
      S_MUL_G: begin
        cmd_o.mul_run = 1'b1;
        cmd_o.src     = wrsi_pkg::SRC_GAIN;
        if (stat_i.mul_last) begin
          state_d = S_ADD_G;
        end
      end
      S_ADD_G: begin
        cmd_o.add_gain = 1'b1;
        state_d        = S_MUL_L;
      end
      S_MUL_L: begin
        cmd_o.mul_run = 1'b1;
        cmd_o.src     = wrsi_pkg::SRC_LOSS;
        if (stat_i.mul_last) begin
          state_d = S_ADD_L;
        end
      end
      S_ADD_L: begin
        cmd_o.add_loss = 1'b1;
        state_d        = S_DIV_G;
      end
      S_DIV_G: begin
        cmd_o.div_run = 1'b1;
        cmd_o.src     = wrsi_pkg::SRC_GAIN;
        if (stat_i.div_last) begin
          state_d = S_DIV_L;
        end
      end
      S_DIV_L: begin
        cmd_o.div_run = 1'b1;
        cmd_o.src     = wrsi_pkg::SRC_LOSS;
        if (stat_i.div_last) begin
          state_d = S_NORM_LOAD;
        end
      end
      S_NORM_LOAD: begin
        if (stat_i.loss_zero) begin
          res_d   = wrsi_pkg::RES_FULL;
          state_d = S_OUT;
        end else begin
          cmd_o.norm_load = 1'b1;
          state_d         = S_NORM;
        end
      end
      S_NORM: begin
        if (stat_i.norm_big) begin
          cmd_o.norm_shift = 1'b1;
        end else if (stat_i.norm_zero) begin
          res_d   = wrsi_pkg::RES_FULL;
          state_d = S_OUT;
        end else begin
          state_d = S_MUL_R;
        end
      end
      S_MUL_R: begin
        cmd_o.mul_run = 1'b1;
        cmd_o.src     = wrsi_pkg::SRC_RSI;
        if (stat_i.mul_last) begin
          state_d = S_DIV_R;
        end
      end
      S_DIV_R: begin
        cmd_o.div_run = 1'b1;
        cmd_o.src     = wrsi_pkg::SRC_RSI;
        if (stat_i.div_last) begin
          res_d   = wrsi_pkg::RES_QUO;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and result kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= wrsi_pkg::RES_NULL;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

// ===== design/wilder_rsi_stream_core.sv =====
// sequence: null items and seeding go from accept to the output; warm-up items add their change;
// a full window divides the averages by the period; a smoothed item scales them by period minus
// one and adds its change first; then up to 24 normalizing shifts, the scale by 100 and the
// final division follow unless the loss average is zero; up to three radix-2 divider passes
// one transaction in flight; a waiting result sits in the output register while the next is taken
// reset: asynchronous active low, clears series state and averages, period back to 14
module wilder_rsi_stream_core #(
  parameter int unsigned MAX_PERIOD  = 1024,
  parameter int unsigned PRICE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wrsi_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [PRICE_WIDTH-1:0] price_i,
  input  logic                          price_absent_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wrsi_pkg::RSI_W-1:0]    rsi_o,
  output logic                          rsi_valid_o,
  output logic                          fault_o
);

  `include "wilder_rsi_stream_core_assert.svh"

  wrsi_pkg::cmd_t    cmd;
  wrsi_pkg::status_t stat;

  // sequencer
  wrsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // arithmetic and state
  wrsi_dpath #(
    .MAX_PERIOD  (MAX_PERIOD),
    .PRICE_WIDTH (PRICE_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .price_i        (price_i),
    .price_absent_i (price_absent_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .rsi_o          (rsi_o),
    .rsi_valid_o    (rsi_valid_o),
    .fault_o        (fault_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

  // only one transaction at work at a time
  `WRSI_ASSERT(a_one_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o)
  // index never above 100
  `WRSI_ASSERT_NEVER(a_rsi_range, out_valid_o && (rsi_o > wrsi_pkg::RSI_FULL))
  // null results carry a zero index
  `WRSI_ASSERT_NEVER(a_null_zero, out_valid_o && !rsi_valid_o && (rsi_o != '0))
  // a fault only comes with a null result
  `WRSI_ASSERT_NEVER(a_fault_null, out_valid_o && fault_o && rsi_valid_o)

endmodule
